@@ rtl/core/rf_pulse_pair_frame_decoder_unit_defines.svh @@
// Assertion macros shared by the checker of the pulse pair frame decoder.
// Depends on nothing; included by the files that hold assertions.
`ifndef RF_PULSE_PAIR_FRAME_DECODER_UNIT_DEFINES_SVH
`define RF_PULSE_PAIR_FRAME_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is low.
`define RFPD_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is low.
`define RFPD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define RFPD_ASSERT_RESET(lbl, clk, pre, post, msg) \
    lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/core/rfpd_pkg.sv @@
// Types, constants and codes of the pulse pair frame decoder.
// Depends on nothing; used by every module of the block.
package rfpd_pkg;

    localparam int FRAME_PULSES  = 118;
    localparam int SYNC_BITS     = 13;
    localparam int FIELD_BITS    = 9;
    localparam int DECODE_PULSES = 2 * (SYNC_BITS + 5 * FIELD_BITS);
    localparam int COUNT_W       = 7;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [SYNC_BITS-1:0] SYNC_PATTERN = 13'h0001;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_DATA_MIN  = 3'd0;
    localparam logic [2:0] CFG_DATA_MAX  = 3'd1;
    localparam logic [2:0] CFG_LONG_THR  = 3'd2;
    localparam logic [2:0] CFG_PAUSE_MIN = 3'd3;
    localparam logic [2:0] CFG_PAUSE_MAX = 3'd4;
    localparam logic [2:0] CFG_SEED      = 3'd5;

    // Field numbers within a frame.
    localparam logic [2:0] FIELD_SYNC  = 3'd0;
    localparam logic [2:0] FIELD_HC_HI = 3'd1;
    localparam logic [2:0] FIELD_HC_LO = 3'd2;
    localparam logic [2:0] FIELD_ADDR  = 3'd3;
    localparam logic [2:0] FIELD_CMD   = 3'd4;
    localparam logic [2:0] FIELD_CHECK = 3'd5;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LENGTH   = 3'd1,
        ST_PULSE    = 3'd2,
        ST_PAUSE    = 3'd3,
        ST_SYMBOL   = 3'd4,
        ST_SYNC     = 3'd5,
        ST_PARITY   = 3'd6,
        ST_CHECKSUM = 3'd7
    } rfpd_status_t;

    typedef struct packed {
        logic [15:0] data_pulse_min;
        logic [15:0] data_pulse_max;
        logic [15:0] long_threshold;
        logic [15:0] pause_min;
        logic [15:0] pause_max;
        logic [7:0]  checksum_seed;
    } rfpd_cfg_t;

    // One classified pulse as it travels from the front to the back.
    typedef struct packed {
        logic is_long;
        logic data_bad;
        logic pause_bad;
        logic last;
    } rfpd_item_t;

    typedef struct packed {
        logic         switch_on;
        logic [7:0]   command;
        logic [7:0]   address;
        logic [15:0]  housecode;
        rfpd_status_t status;
    } rfpd_result_t;

endpackage

@@ rtl/core/rfpd_classify.sv @@
// Front stage: compares one pulse against the configured windows.
// Depends on rfpd_pkg.
module rfpd_classify (
    input  logic [15:0]        pulse_us,
    input  logic               frame_end,
    input  rfpd_pkg::rfpd_cfg_t cfg,
    output rfpd_pkg::rfpd_item_t item
);

    always_comb begin
        item.is_long   = pulse_us > cfg.long_threshold;
        item.data_bad  = (pulse_us < cfg.data_pulse_min) || (pulse_us > cfg.data_pulse_max);
        item.pause_bad = (pulse_us < cfg.pause_min) || (pulse_us > cfg.pause_max);
        item.last      = frame_end;
    end

endmodule

@@ rtl/core/rfpd_queue.sv @@
// Short first-in first-out queue of classified pulses between front and back.
// Depends on rfpd_pkg.
module rfpd_queue #(
    parameter int DEPTH = rfpd_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  rfpd_pkg::rfpd_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output rfpd_pkg::rfpd_item_t pop_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rfpd_pkg::rfpd_item_t slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          push, pop;

    assign push_ready = fill_reg != CW'(DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        fill_next = fill_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/core/rfpd_decode.sv @@
// Back stage: pairs pulses into bits, assembles and checks the fields and
// holds the result register. Depends on rfpd_pkg.
module rfpd_decode (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  rfpd_pkg::rfpd_item_t   item,
    input  logic [7:0]             checksum_seed,
    output logic                   res_valid,
    input  logic                   res_ready,
    output rfpd_pkg::rfpd_result_t res
);

    localparam int CW = rfpd_pkg::COUNT_W;
    localparam int SW = rfpd_pkg::SYNC_BITS;

    logic [CW-1:0]          count_reg, count_next;
    logic                   first_long_reg, first_long_next;
    logic [SW-1:0]          shift_reg, shift_next;
    logic [3:0]             bit_idx_reg, bit_idx_next;
    logic [2:0]             field_reg, field_next;
    logic [7:0]             acc_reg, acc_next;
    logic [15:0]            hc_reg, hc_next;
    logic [7:0]             addr_reg, addr_next;
    logic [7:0]             cmd_reg, cmd_next;
    logic                   range_err_reg, range_err_next;
    rfpd_pkg::rfpd_status_t dec_err_reg, dec_err_next;
    logic                   too_long_reg, too_long_next;
    logic                   res_valid_reg, res_valid_next;
    rfpd_pkg::rfpd_result_t res_reg, res_next;
    logic                   take;

    // A frame end needs the result register; other pulses always pass.
    assign item_ready = !item.last || !res_valid_reg || res_ready;
    assign take       = item_valid && item_ready;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    always_comb begin
        logic [7:0]             acc_cur;
        logic                   bit_val;
        logic [SW-1:0]          shift_new;
        logic [3:0]             idx_new;
        logic [3:0]             field_len;
        logic [7:0]             byte_val;
        rfpd_pkg::rfpd_status_t status;

        count_next      = count_reg;
        first_long_next = first_long_reg;
        shift_next      = shift_reg;
        bit_idx_next    = bit_idx_reg;
        field_next      = field_reg;
        hc_next         = hc_reg;
        addr_next       = addr_reg;
        cmd_next        = cmd_reg;
        range_err_next  = range_err_reg;
        dec_err_next    = dec_err_reg;
        too_long_next   = too_long_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        res_next        = res_reg;
        bit_val         = 1'b0;
        shift_new       = '0;
        idx_new         = '0;
        field_len       = '0;
        byte_val        = '0;
        status          = rfpd_pkg::ST_OK;

        // The first pulse of a frame starts the checksum from the seed.
        acc_cur  = (count_reg == '0) ? checksum_seed : acc_reg;
        acc_next = acc_reg;

        if (take && !item.last) begin
            acc_next = acc_cur;
            if (count_reg >= CW'(rfpd_pkg::FRAME_PULSES - 1)) begin
                too_long_next = 1'b1;
            end
            if (item.data_bad) begin
                range_err_next = 1'b1;
            end
            if (count_reg < CW'(rfpd_pkg::DECODE_PULSES)) begin
                if (!count_reg[0]) begin
                    first_long_next = item.is_long;
                end else begin
                    if (first_long_reg != item.is_long) begin
                        if (dec_err_next == rfpd_pkg::ST_OK) begin
                            dec_err_next = rfpd_pkg::ST_SYMBOL;
                        end
                    end else begin
                        bit_val = item.is_long;
                    end
                    shift_new = {shift_reg[SW-2:0], bit_val};
                    idx_new   = bit_idx_reg + 4'd1;
                    field_len = (field_reg == rfpd_pkg::FIELD_SYNC) ?
                                4'(rfpd_pkg::SYNC_BITS) : 4'(rfpd_pkg::FIELD_BITS);
                    byte_val  = shift_new[8:1];
                    if ((field_reg <= rfpd_pkg::FIELD_CHECK) && (idx_new >= field_len)) begin
                        if (field_reg == rfpd_pkg::FIELD_SYNC) begin
                            if (shift_new != rfpd_pkg::SYNC_PATTERN &&
                                dec_err_next == rfpd_pkg::ST_OK) begin
                                dec_err_next = rfpd_pkg::ST_SYNC;
                            end
                        end else if (^shift_new[8:0]) begin
                            if (dec_err_next == rfpd_pkg::ST_OK) begin
                                dec_err_next = rfpd_pkg::ST_PARITY;
                            end
                        end else begin
                            unique case (field_reg)
                                rfpd_pkg::FIELD_HC_HI: begin
                                    hc_next  = {byte_val, hc_reg[7:0]};
                                    acc_next = acc_cur + byte_val;
                                end
                                rfpd_pkg::FIELD_HC_LO: begin
                                    hc_next  = {hc_reg[15:8], byte_val};
                                    acc_next = acc_cur + byte_val;
                                end
                                rfpd_pkg::FIELD_ADDR: begin
                                    addr_next = byte_val;
                                    acc_next  = acc_cur + byte_val;
                                end
                                rfpd_pkg::FIELD_CMD: begin
                                    cmd_next = byte_val;
                                    acc_next = acc_cur + byte_val;
                                end
                                rfpd_pkg::FIELD_CHECK: begin
                                    if (byte_val != acc_cur &&
                                        dec_err_next == rfpd_pkg::ST_OK) begin
                                        dec_err_next = rfpd_pkg::ST_CHECKSUM;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        field_next   = field_reg + 3'd1;
                        bit_idx_next = '0;
                        shift_next   = '0;
                    end else begin
                        shift_next   = shift_new;
                        bit_idx_next = idx_new;
                    end
                end
            end
            if (count_reg != '1) begin
                count_next = count_reg + CW'(1);
            end
        end else if (take) begin
            if (too_long_reg || count_reg != CW'(rfpd_pkg::FRAME_PULSES - 1)) begin
                status = rfpd_pkg::ST_LENGTH;
            end else if (range_err_reg) begin
                status = rfpd_pkg::ST_PULSE;
            end else if (item.pause_bad) begin
                status = rfpd_pkg::ST_PAUSE;
            end else begin
                status = dec_err_reg;
            end
            res_valid_next = 1'b1;
            res_next       = '0;
            res_next.status = status;
            if (status == rfpd_pkg::ST_OK) begin
                res_next.housecode = hc_reg;
                res_next.address   = addr_reg;
                res_next.command   = cmd_reg;
                res_next.switch_on = cmd_reg != 8'd0;
            end
            count_next      = '0;
            first_long_next = 1'b0;
            shift_next      = '0;
            bit_idx_next    = '0;
            field_next      = rfpd_pkg::FIELD_SYNC;
            acc_next        = checksum_seed;
            hc_next         = '0;
            addr_next       = '0;
            cmd_next        = '0;
            range_err_next  = 1'b0;
            dec_err_next    = rfpd_pkg::ST_OK;
            too_long_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            first_long_reg <= 1'b0;
            shift_reg      <= '0;
            bit_idx_reg    <= '0;
            field_reg      <= rfpd_pkg::FIELD_SYNC;
            acc_reg        <= checksum_seed;
            hc_reg         <= '0;
            addr_reg       <= '0;
            cmd_reg        <= '0;
            range_err_reg  <= 1'b0;
            dec_err_reg    <= rfpd_pkg::ST_OK;
            too_long_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            count_reg      <= count_next;
            first_long_reg <= first_long_next;
            shift_reg      <= shift_next;
            bit_idx_reg    <= bit_idx_next;
            field_reg      <= field_next;
            acc_reg        <= acc_next;
            hc_reg         <= hc_next;
            addr_reg       <= addr_next;
            cmd_reg        <= cmd_next;
            range_err_reg  <= range_err_next;
            dec_err_reg    <= dec_err_next;
            too_long_reg   <= too_long_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

endmodule

@@ rtl/core/rf_pulse_pair_frame_decoder_unit.sv @@
// Top level of the pulse pair radio frame decoder.
// Depends on rfpd_pkg, rfpd_classify, rfpd_queue and rfpd_decode.
//
// Usage:
// Pulse durations in microseconds arrive on the s_ stream, one request per
// pulse, with s_tlast set on the final pause of a frame. Every pulse before
// it is classified against the data window and the long threshold; the last
// one against the pause window. A classified pulse enters a short queue and
// the decoder behind it pairs pulses into bits and checks sync, parity and
// checksum. Exactly one result request leaves on the m_ stream per frame, at
// the pulse that carries s_tlast; other pulses produce nothing.
// Throughput is one pulse per cycle while the queue is not full.
// From the accepted final pause to m_tvalid, the pulse is written into a
// queue slot, is decoded once it reaches the head of the queue, and the
// decode step then loads the result register.
// When the receiver stalls, the result register holds its request and the
// decoder keeps consuming ordinary pulses; only the next frame end waits,
// and once the queue is full s_tready falls until the result is taken.
// Reset (aresetn low, synchronous) empties the queue, clears the frame state
// and restores the configuration registers to their default windows.
// The cfg_ write channel is always ready; indexes 6 and 7 are ignored. It
// must only be written while no frame is in flight.
module rf_pulse_pair_frame_decoder_unit #(
    parameter int QUEUE_DEPTH = rfpd_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Pulse input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] pulse_us
    input  logic        s_tlast,   // frame_end
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [2:0] status, [18:3] housecode,
                                   // [26:19] address, [34:27] command,
                                   // [35] switch_on, [39:36] zero
);

    rfpd_pkg::rfpd_cfg_t    cfg_reg, cfg_next;
    rfpd_pkg::rfpd_item_t   front_item, back_item;
    rfpd_pkg::rfpd_result_t result;
    logic                   back_valid, back_ready;

    assign cfg_ready = 1'b1;

    // Register bank: each request writes one register selected by index.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                rfpd_pkg::CFG_DATA_MIN:  cfg_next.data_pulse_min = cfg_data;
                rfpd_pkg::CFG_DATA_MAX:  cfg_next.data_pulse_max = cfg_data;
                rfpd_pkg::CFG_LONG_THR:  cfg_next.long_threshold = cfg_data;
                rfpd_pkg::CFG_PAUSE_MIN: cfg_next.pause_min      = cfg_data;
                rfpd_pkg::CFG_PAUSE_MAX: cfg_next.pause_max      = cfg_data;
                rfpd_pkg::CFG_SEED:      cfg_next.checksum_seed  = cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.data_pulse_min <= 16'd300;
            cfg_reg.data_pulse_max <= 16'd700;
            cfg_reg.long_threshold <= 16'd500;
            cfg_reg.pause_min      <= 16'd4300;
            cfg_reg.pause_max      <= 16'd14300;
            cfg_reg.checksum_seed  <= 8'd6;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rfpd_classify u_classify (
        .pulse_us  (s_tdata),
        .frame_end (s_tlast),
        .cfg       (cfg_reg),
        .item      (front_item)
    );

    rfpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    rfpd_decode u_decode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (back_valid),
        .item_ready    (back_ready),
        .item          (back_item),
        .checksum_seed (cfg_reg.checksum_seed),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .res           (result)
    );

    assign m_tdata = {4'd0, result};

endmodule

@@ rtl/core/rfpd_checker.sv @@
// Port-level checks of the pulse pair frame decoder and their bind.
// Depends on rf_pulse_pair_frame_decoder_unit_defines.svh and rfpd_pkg.
`include "rf_pulse_pair_frame_decoder_unit_defines.svh"

module rfpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // No result may be pending right after reset.
    `RFPD_ASSERT_RESET(a_reset_idle, aclk, !aresetn, !m_tvalid, "result valid after reset")

    // A stalled result keeps its data.
    `RFPD_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata),
        "result changed under stall")

    // A failed frame reports no decoded fields.
    `RFPD_ASSERT_NOW(a_err_zero, aclk, aresetn,
        m_tvalid && (m_tdata[2:0] != rfpd_pkg::ST_OK), m_tdata[39:3] == 37'd0,
        "fields set on failed frame")

    // The on flag follows the command byte.
    `RFPD_ASSERT_NOW(a_switch, aclk, aresetn, m_tvalid,
        m_tdata[35] == (m_tdata[34:27] != 8'd0), "switch flag mismatch")

endmodule

bind rf_pulse_pair_frame_decoder_unit rfpd_checker u_rfpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
